### hw/rtl/tcgw_pkg.sv
// Shared types and constants of the text console grid writer.
`default_nettype none

package tcgw_pkg;

	// operation codes of the func field
	localparam logic [2:0] FN_PUT_CHAR   = 3'd0;
	localparam logic [2:0] FN_READ_CELL  = 3'd1;
	localparam logic [2:0] FN_CLEAR      = 3'd2;
	localparam logic [2:0] FN_SET_COLOUR = 3'd3;
	localparam logic [2:0] FN_SET_CURSOR = 3'd4;
	localparam logic [2:0] FN_WRITE_CELL = 3'd5;

	// control bytes seen by put char
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [3:0] RESET_FORE = 4'hF;
	localparam logic [3:0] RESET_BACK = 4'h0;
	localparam int         CELL_W     = 16;

	// configuration registers
	localparam int         CFG_IDX_W          = 2;
	localparam logic [1:0] REG_ACTIVE_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ACTIVE_ROWS    = 2'd1;
	localparam logic [7:0] RESET_COLS         = 8'd70;
	localparam logic [6:0] RESET_ROWS         = 7'd20;
	localparam int         MIN_COLS           = 10;
	localparam int         MIN_ROWS           = 4;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] char_code;
		logic [6:0] col;
		logic [5:0] row;
		logic [3:0] fg;
		logic [3:0] bg;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_char;
		logic [7:0] read_attr;
		logic [7:0] cursor_col_out;
		logic [5:0] cursor_row_out;
	} out_item_t;

endpackage

`default_nettype wire

### hw/rtl/tcgw_cell_ram.sv
// Cell store: one write port, one read port with registered read data.
`default_nettype none

module tcgw_cell_ram import tcgw_pkg::*; #(
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [CELL_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [CELL_W-1:0]        rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/text_console_grid_writer.sv
// Top level of the text console grid writer: sequencer, cursor state and cell store.
//
// A character grid of MAX_COLS x MAX_ROWS cells (char in the low byte, attribute
// (bg<<4)|fg in the high byte) with a cursor and a current color pair. After reset
// the block runs a clearing pass over the whole store, one cell a cycle, and takes
// no item until it ends; configuration writes are taken at any time. Items are
// handled one at a time by a sequencer that drives a single row/column sweep
// counter and one store port pair. Each item passes from an execute state to a
// done state; a printable byte adds a put state, an in-grid read cell a read wait
// state, and tab a remainder step by repeated subtraction. A scroll copies rows
// 1 to rows-1 up by one row through the read port, then writes the blank bottom
// row; clear blanks every active row. The next item is accepted while a result
// still waits in the output register.
`default_nettype none

module text_console_grid_writer import tcgw_pkg::*; #(
	parameter int MAX_COLS  = 128,
	parameter int MAX_ROWS  = 64,
	parameter int TAB_WIDTH = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_COLS + 1);         // cursor column, may equal cols
	localparam int LW    = $clog2(MAX_ROWS);             // cursor line
	localparam int RW1   = $clog2(MAX_ROWS + 1);         // row count
	localparam int TW    = $clog2(MAX_COLS + TAB_WIDTH + 1);
	localparam int CXW   = (CW > 7) ? CW : 7;
	localparam int RXW   = (RW1 > 6) ? RW1 : 6;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_EXEC, S_PUT, S_TAB, S_COPY, S_DRAIN,
		S_FILL, S_CLEAR, S_RDWAIT, S_DONE
	} state_t;

	function automatic logic [CW-1:0] clamp_cols(input logic [7:0] v);
		logic [CW-1:0] r;
		if (int'(v) < MIN_COLS) r = CW'(MIN_COLS);
		else if (int'(v) > MAX_COLS) r = CW'(MAX_COLS);
		else r = CW'(v);
		return r;
	endfunction

	function automatic logic [RW1-1:0] clamp_rows(input logic [6:0] v);
		logic [RW1-1:0] r;
		if (int'(v) < MIN_ROWS) r = RW1'(MIN_ROWS);
		else if (int'(v) > MAX_ROWS) r = RW1'(MAX_ROWS);
		else r = RW1'(v);
		return r;
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(MAX_COLS) + AW'(c);
	endfunction

	state_t          state_q;
	in_item_t        op_q;
	logic [7:0]      act_cols_q;
	logic [6:0]      act_rows_q;
	logic [CW-1:0]   cur_col_q;
	logic [LW-1:0]   cur_line_q;
	logic [3:0]      fore_q;
	logic [3:0]      back_q;
	logic [AW-1:0]   init_q;
	logic [CW-1:0]   sc_q;
	logic [LW-1:0]   sr_q;
	logic [AW-1:0]   base_q;
	logic            pend_q;
	logic [AW-1:0]   pend_addr_q;
	logic            after_put_q;
	logic [CW-1:0]   rem_q;
	logic [7:0]      res_char_q;
	logic [7:0]      res_attr_q;
	logic            out_valid_q;
	out_item_t       out_q;

	logic [CW-1:0]   cols;
	logic [RW1-1:0]  rows;
	logic [7:0]      cur_attr;
	logic            op_in_grid;
	logic            line_last;
	logic            sc_last;
	logic            sr_last;
	logic [AW-1:0]   sweep_addr;
	logic [TW-1:0]   tab_col;
	logic [CW-1:0]   cfg_cols;
	logic [RW1-1:0]  cfg_rows;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign cols       = clamp_cols(act_cols_q);
	assign rows       = clamp_rows(act_rows_q);
	assign cur_attr   = {back_q, fore_q};
	assign op_in_grid = (CXW'(op_q.col) < CXW'(cols)) && (RXW'(op_q.row) < RXW'(rows));
	assign line_last  = (RW1'(cur_line_q) + RW1'(1)) >= rows;
	assign sc_last    = sc_q == (cols - CW'(1));
	assign sr_last    = RW1'(sr_q) == (rows - RW1'(1));
	assign sweep_addr = base_q + AW'(sc_q);
	assign tab_col    = TW'(cur_col_q) + TW'(TAB_WIDTH) - TW'(rem_q);
	assign cfg_cols   = clamp_cols(cfg_data);
	assign cfg_rows   = clamp_rows(cfg_data[6:0]);

	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// store ports: the delayed copy write wins over every other write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_addr;
		ram_wdata = {cur_attr, BLANK_CHAR};
		ram_re    = 1'b0;
		ram_raddr = sweep_addr;
		if (pend_q) begin
			ram_we    = 1'b1;
			ram_waddr = pend_addr_q;
			ram_wdata = ram_rdata;
		end else begin
			case (state_q)
				S_INIT: begin
					ram_we    = 1'b1;
					ram_waddr = init_q;
					ram_wdata = {RESET_BACK, RESET_FORE, BLANK_CHAR};
				end
				S_EXEC: begin
					if (op_q.func == FN_PUT_CHAR && op_q.char_code == CH_BS
							&& cur_col_q != '0) begin
						ram_we    = 1'b1;
						ram_waddr = cell_addr(cur_line_q, cur_col_q - CW'(1));
					end else if (op_q.func == FN_WRITE_CELL && op_in_grid) begin
						ram_we    = 1'b1;
						ram_waddr = cell_addr(LW'(op_q.row), CW'(op_q.col));
						ram_wdata = {op_q.bg, op_q.fg, op_q.char_code};
					end
				end
				S_PUT: begin
					ram_we    = 1'b1;
					ram_waddr = cell_addr(cur_line_q, cur_col_q);
					ram_wdata = {cur_attr, op_q.char_code};
				end
				S_FILL, S_CLEAR: begin
					ram_we = 1'b1;
				end
				default: begin
				end
			endcase
		end
		case (state_q)
			S_COPY: begin
				ram_re = 1'b1;
			end
			S_EXEC: begin
				ram_re    = op_q.func == FN_READ_CELL && op_in_grid;
				ram_raddr = cell_addr(LW'(op_q.row), CW'(op_q.col));
			end
			default: begin
			end
		endcase
	end

	tcgw_cell_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			op_q        <= '0;
			act_cols_q  <= RESET_COLS;
			act_rows_q  <= RESET_ROWS;
			cur_col_q   <= '0;
			cur_line_q  <= '0;
			fore_q      <= RESET_FORE;
			back_q      <= RESET_BACK;
			init_q      <= '0;
			sc_q        <= '0;
			sr_q        <= '0;
			base_q      <= '0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
			after_put_q <= 1'b0;
			rem_q       <= '0;
			res_char_q  <= '0;
			res_attr_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			pend_q      <= state_q == S_COPY;
			pend_addr_q <= sweep_addr - AW'(MAX_COLS);
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q       <= in_data;
						res_char_q <= '0;
						res_attr_q <= '0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (op_q.func)
						FN_PUT_CHAR: begin
							case (op_q.char_code)
								CH_LF: begin
									cur_col_q <= '0;
									if (line_last) begin
										after_put_q <= 1'b0;
										sr_q        <= LW'(1);
										sc_q        <= '0;
										base_q      <= AW'(MAX_COLS);
										state_q     <= S_COPY;
									end else begin
										cur_line_q <= cur_line_q + LW'(1);
									end
								end
								CH_CR: begin
									cur_col_q <= '0;
								end
								CH_BS: begin
									if (cur_col_q != '0) begin
										cur_col_q <= cur_col_q - CW'(1);
									end
								end
								CH_TAB: begin
									rem_q   <= cur_col_q;
									state_q <= S_TAB;
								end
								default: begin
									state_q <= S_PUT;
									// deferred wrap
									if (cur_col_q >= cols) begin
										cur_col_q <= '0;
										if (line_last) begin
											after_put_q <= 1'b1;
											sr_q        <= LW'(1);
											sc_q        <= '0;
											base_q      <= AW'(MAX_COLS);
											state_q     <= S_COPY;
										end else begin
											cur_line_q <= cur_line_q + LW'(1);
										end
									end
								end
							endcase
						end
						FN_READ_CELL: begin
							if (op_in_grid) begin
								state_q <= S_RDWAIT;
							end
						end
						FN_CLEAR: begin
							back_q     <= op_q.bg;
							cur_col_q  <= '0;
							cur_line_q <= '0;
							sr_q       <= '0;
							sc_q       <= '0;
							base_q     <= '0;
							state_q    <= S_CLEAR;
						end
						FN_SET_COLOUR: begin
							fore_q <= op_q.fg;
							back_q <= op_q.bg;
						end
						FN_SET_CURSOR: begin
							if (CXW'(op_q.col) < CXW'(cols)) begin
								cur_col_q <= CW'(op_q.col);
							end
							if (RXW'(op_q.row) < RXW'(rows)) begin
								cur_line_q <= LW'(op_q.row);
							end
						end
						default: begin
						end
					endcase
				end
				S_PUT: begin
					cur_col_q <= cur_col_q + CW'(1);
					state_q   <= S_DONE;
				end
				S_TAB: begin
					// remainder by repeated subtraction
					if (int'(rem_q) >= TAB_WIDTH) begin
						rem_q <= rem_q - CW'(TAB_WIDTH);
					end else if (tab_col >= TW'(cols)) begin
						cur_col_q <= '0;
						if (line_last) begin
							after_put_q <= 1'b0;
							sr_q        <= LW'(1);
							sc_q        <= '0;
							base_q      <= AW'(MAX_COLS);
							state_q     <= S_COPY;
						end else begin
							cur_line_q <= cur_line_q + LW'(1);
							state_q    <= S_DONE;
						end
					end else begin
						cur_col_q <= CW'(tab_col);
						state_q   <= S_DONE;
					end
				end
				S_COPY: begin
					// read row sr; the registered read data is written into row sr-1 by the delayed copy write
					if (sc_last) begin
						sc_q <= '0;
						if (sr_last) begin
							state_q <= S_DRAIN;
						end else begin
							sr_q   <= sr_q + LW'(1);
							base_q <= base_q + AW'(MAX_COLS);
						end
					end else begin
						sc_q <= sc_q + CW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_FILL;
				end
				S_FILL: begin
					sc_q <= sc_q + CW'(1);
					if (sc_last) begin
						state_q <= after_put_q ? S_PUT : S_DONE;
					end
				end
				S_CLEAR: begin
					if (sc_last) begin
						sc_q <= '0;
						if (sr_last) begin
							state_q <= S_DONE;
						end else begin
							sr_q   <= sr_q + LW'(1);
							base_q <= base_q + AW'(MAX_COLS);
						end
					end else begin
						sc_q <= sc_q + CW'(1);
					end
				end
				S_RDWAIT: begin
					res_char_q <= ram_rdata[7:0];
					res_attr_q <= ram_rdata[15:8];
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q.read_char      <= res_char_q;
						out_q.read_attr      <= res_attr_q;
						out_q.cursor_col_out <= 8'(cur_col_q);
						out_q.cursor_row_out <= 6'(cur_line_q);
						out_valid_q          <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// register writes; a shrunk grid pulls the cursor back in
			if (cfg_valid) begin
				case (cfg_index)
					REG_ACTIVE_COLUMNS: begin
						act_cols_q <= cfg_data;
						if (cur_col_q > cfg_cols) begin
							cur_col_q <= cfg_cols;
						end
					end
					REG_ACTIVE_ROWS: begin
						act_rows_q <= cfg_data[6:0];
						if (RW1'(cur_line_q) >= cfg_rows) begin
							cur_line_q <= LW'(cfg_rows - RW1'(1));
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the text console grid writer.
`timescale 1ns / 1ps

module tb_top import tcgw_pkg::*; ();

	localparam int GRID_COLS_MAX = 128;
	localparam int GRID_ROWS_MAX = 64;
	localparam int TAB_STOP      = 8;

	// func codes the block treats as no-ops
	localparam logic [2:0] FN_RSVD6 = 3'd6;
	localparam logic [2:0] FN_RSVD7 = 3'd7;
	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	always #6 clk = ~clk;

	text_console_grid_writer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the console state
	logic [CELL_W-1:0] cell_img [GRID_COLS_MAX*GRID_ROWS_MAX];
	logic [7:0] cur_col;
	logic [5:0] cur_row;
	logic [3:0] fore_clr;
	logic [3:0] back_clr;
	logic [7:0] cols_reg;
	logic [6:0] rows_reg;

	in_item_t  cmd_backlog [$];
	out_item_t status_due [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;

	function automatic int eff_cols();
		int c;
		c = int'(cols_reg);
		if (c < MIN_COLS) c = MIN_COLS;
		if (c > GRID_COLS_MAX) c = GRID_COLS_MAX;
		return c;
	endfunction

	function automatic int eff_rows();
		int r;
		r = int'(rows_reg);
		if (r < MIN_ROWS) r = MIN_ROWS;
		if (r > GRID_ROWS_MAX) r = GRID_ROWS_MAX;
		return r;
	endfunction

	function automatic void scroll_grid();
		int rows;
		int cols;
		rows = eff_rows();
		cols = eff_cols();
		for (int r = 0; r + 1 < rows; r++)
			for (int c = 0; c < cols; c++)
				cell_img[r*GRID_COLS_MAX + c] = cell_img[(r+1)*GRID_COLS_MAX + c];
		for (int c = 0; c < cols; c++)
			cell_img[(rows-1)*GRID_COLS_MAX + c] = {back_clr, fore_clr, BLANK_CHAR};
	endfunction

	function automatic out_item_t console_step(in_item_t it);
		int cols;
		int rows;
		int c;
		int r;
		out_item_t res;
		cols = eff_cols();
		rows = eff_rows();
		c = int'(cur_col);
		r = int'(cur_row);
		res = '0;
		case (it.func)
			FN_PUT_CHAR: begin
				case (it.char_code)
					CH_LF: begin
						c = 0;
						r++;
					end
					CH_CR: c = 0;
					CH_BS: begin
						if (c > 0) begin
							c--;
							cell_img[r*GRID_COLS_MAX + c] = {back_clr, fore_clr, BLANK_CHAR};
						end
					end
					CH_TAB: begin
						c = (c + TAB_STOP) / TAB_STOP * TAB_STOP;
						if (c >= cols) begin
							c = 0;
							r++;
						end
					end
					default: begin
						// deferred wrap: column may sit at cols until the next printable
						if (c >= cols) begin
							c = 0;
							r++;
						end
						if (r >= rows) begin
							scroll_grid();
							r = rows - 1;
						end
						cell_img[r*GRID_COLS_MAX + c] = {back_clr, fore_clr, it.char_code};
						c++;
					end
				endcase
				if (r >= rows) begin
					scroll_grid();
					r = rows - 1;
				end
			end
			FN_READ_CELL: begin
				if (it.row < rows && it.col < cols)
					{res.read_attr, res.read_char} = cell_img[it.row*GRID_COLS_MAX + it.col];
			end
			FN_CLEAR: begin
				back_clr = it.bg;
				for (int y = 0; y < rows; y++)
					for (int x = 0; x < cols; x++)
						cell_img[y*GRID_COLS_MAX + x] = {back_clr, fore_clr, BLANK_CHAR};
				c = 0;
				r = 0;
			end
			FN_SET_COLOUR: begin
				fore_clr = it.fg;
				back_clr = it.bg;
			end
			FN_SET_CURSOR: begin
				if (it.col < cols) c = int'(it.col);
				if (it.row < rows) r = int'(it.row);
			end
			FN_WRITE_CELL: begin
				if (it.row < rows && it.col < cols)
					cell_img[it.row*GRID_COLS_MAX + it.col] = {it.bg, it.fg, it.char_code};
			end
			default: ;
		endcase
		cur_col = c[7:0];
		cur_row = r[5:0];
		res.cursor_col_out = c[7:0];
		res.cursor_row_out = r[5:0];
		return res;
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		if (idx == REG_ACTIVE_COLUMNS)
			cols_reg = val;
		else if (idx == REG_ACTIVE_ROWS)
			rows_reg = val[6:0];
		else
			return;
		// shrinking the grid drags the cursor back inside
		if (cur_col > eff_cols()) cur_col = 8'(eff_cols());
		if (cur_row >= eff_rows()) cur_row = 6'(eff_rows() - 1);
	endfunction

	function automatic in_item_t random_cmd(bit lite);
		in_item_t it;
		int pick;
		int cols;
		int rows;
		it = in_item_t'($urandom);
		cols = eff_cols();
		rows = eff_rows();
		pick = $urandom_range(99);
		if (pick < 55) begin
			it.func = FN_PUT_CHAR;
			pick = $urandom_range(9);
			if (pick < 6) begin
				it.char_code = 8'($urandom_range(8'h7E, 8'h20));
			end else if (pick < 8) begin
				case ($urandom_range(lite ? 1 : 3))
					0: it.char_code = CH_CR;
					1: it.char_code = CH_BS;
					2: it.char_code = CH_TAB;
					default: it.char_code = CH_LF;
				endcase
			end
		end else begin
			if (pick < 70) it.func = FN_READ_CELL;
			else if (pick < 78) it.func = FN_WRITE_CELL;
			else if (pick < 88) it.func = FN_SET_CURSOR;
			else if (pick < 94) it.func = FN_SET_COLOUR;
			else if (pick < 97) it.func = lite ? FN_READ_CELL : FN_CLEAR;
			else it.func = $urandom_range(1) ? FN_RSVD7 : FN_RSVD6;
			// mostly in-grid coordinates, the rest anywhere in the field
			if ($urandom_range(4) != 0) begin
				it.col = 7'($urandom_range(cols - 1));
				it.row = 6'($urandom_range(rows - 1));
			end
		end
		return it;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%t %s mismatch: expected %02h actual %02h", $time, name, want, got);
		end
	endfunction

	// command driver: predict on each accepted beat, then load the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				status_due.push_back(console_step(in_data));
			if (!in_valid || in_ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= cmd_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// status monitor
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (status_due.size() == 0) begin
					mismatches++;
					$display("%t unexpected status beat: expected none actual %h",
						$time, out_data);
				end else begin
					want = status_due.pop_front();
					check_field("read_char", want.read_char, out_data.read_char);
					check_field("read_attr", want.read_attr, out_data.read_attr);
					check_field("col_pos", want.cursor_col_out, out_data.cursor_col_out);
					check_field("row_pos", {2'b00, want.cursor_row_out},
						{2'b00, out_data.cursor_row_out});
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_cmd(logic [2:0] f, logic [7:0] ch, logic [6:0] c, logic [5:0] r,
		logic [3:0] fg, logic [3:0] bg);
		cmd_backlog.push_back({f, ch, c, r, fg, bg});
	endtask

	task automatic queue_random(int count, bit lite);
		@(negedge clk);
		repeat (count) cmd_backlog.push_back(random_cmd(lite));
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || status_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_cfg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		for (int i = 0; i < GRID_COLS_MAX*GRID_ROWS_MAX; i++)
			cell_img[i] = {RESET_BACK, RESET_FORE, BLANK_CHAR};
		cur_col = '0;
		cur_row = '0;
		fore_clr = RESET_FORE;
		back_clr = RESET_BACK;
		cols_reg = RESET_COLS;
		rows_reg = RESET_ROWS;
		send_idle_pct = 6;
		recv_idle_pct = 75;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass on the reset grid, 70 x 20
		@(negedge clk);
		queue_cmd(FN_READ_CELL, 8'h00, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, 8'h41, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, 8'h00, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, 8'hFF, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, CH_BS, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, CH_CR, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, CH_BS, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, CH_TAB, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_SET_CURSOR, 8'h00, 7'd69, 6'd19, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, 8'h78, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, 8'h79, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_READ_CELL, 8'h00, 7'd69, 6'd18, 4'h0, 4'h0);
		queue_cmd(FN_SET_CURSOR, 8'h00, 7'd64, 6'd3, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, CH_TAB, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_SET_CURSOR, 8'h00, 7'd127, 6'd5, 4'h0, 4'h0);
		queue_cmd(FN_SET_CURSOR, 8'h00, 7'd3, 6'd63, 4'h0, 4'h0);
		queue_cmd(FN_SET_COLOUR, 8'h00, 7'd0, 6'd0, 4'h0, 4'hF);
		queue_cmd(FN_PUT_CHAR, 8'h7E, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_WRITE_CELL, 8'h5A, 7'd69, 6'd19, 4'h5, 4'hA);
		queue_cmd(FN_READ_CELL, 8'h00, 7'd69, 6'd19, 4'h0, 4'h0);
		queue_cmd(FN_WRITE_CELL, 8'h33, 7'd70, 6'd0, 4'h1, 4'h2);
		queue_cmd(FN_READ_CELL, 8'h00, 7'd127, 6'd63, 4'h0, 4'h0);
		queue_cmd(FN_SET_CURSOR, 8'h00, 7'd0, 6'd19, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, CH_LF, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_RSVD6, 8'hFF, 7'd127, 6'd63, 4'hF, 4'hF);
		queue_cmd(FN_RSVD7, 8'hFF, 7'd127, 6'd63, 4'hF, 4'hF);
		queue_cmd(FN_CLEAR, 8'h00, 7'd0, 6'd0, 4'h0, 4'h3);
		queue_cmd(FN_READ_CELL, 8'h00, 7'd10, 6'd10, 4'h0, 4'h0);

		// smallest grid
		wait_quiet();
		write_reg(REG_ACTIVE_COLUMNS, 8'd10);
		write_reg(REG_ACTIVE_ROWS, 8'd4);
		queue_random(400, 1'b0);

		// zero registers clamp to the minimum; spare indexes change nothing
		wait_quiet();
		send_idle_pct = 75;
		recv_idle_pct = 6;
		write_reg(REG_ACTIVE_COLUMNS, 8'd0);
		write_reg(REG_ACTIVE_ROWS, 8'd0);
		write_reg(REG_SPARE2, 8'hFF);
		write_reg(REG_SPARE3, 8'h55);
		queue_random(250, 1'b0);

		// mid-size grid, with a full drain halfway through
		wait_quiet();
		write_reg(REG_ACTIVE_COLUMNS, 8'd33);
		write_reg(REG_ACTIVE_ROWS, 8'd7);
		queue_random(200, 1'b0);
		wait_quiet();
		queue_random(200, 1'b0);

		// oversized registers clamp to the full 128 x 64 grid; keep scrolls rare here
		wait_quiet();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_ACTIVE_COLUMNS, 8'hFF);
		write_reg(REG_ACTIVE_ROWS, 8'hFF);
		@(negedge clk);
		queue_cmd(FN_SET_CURSOR, 8'h00, 7'd127, 6'd63, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, 8'h50, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_PUT_CHAR, 8'h51, 7'd0, 6'd0, 4'h0, 4'h0);
		queue_cmd(FN_READ_CELL, 8'h00, 7'd127, 6'd62, 4'h0, 4'h0);
		queue_cmd(FN_READ_CELL, 8'h00, 7'd0, 6'd63, 4'h0, 4'h0);
		queue_cmd(FN_CLEAR, 8'h00, 7'd0, 6'd0, 4'h0, 4'hC);
		queue_random(100, 1'b1);

		// shrink: cursor gets pulled in
		wait_quiet();
		write_reg(REG_ACTIVE_COLUMNS, 8'd20);
		write_reg(REG_ACTIVE_ROWS, 8'd5);
		queue_random(400, 1'b0);

		// narrow and tall
		wait_quiet();
		write_reg(REG_ACTIVE_COLUMNS, 8'd10);
		write_reg(REG_ACTIVE_ROWS, 8'd64);
		queue_random(100, 1'b0);

		wait_quiet();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
